// ===== design/bsc_pkg.sv =====
// Shared types and constants for the barometric sensor compensation block.
// Used by bsc_apb_regs, bsc_pipe and baro_sensor_compensation; no dependencies.
`default_nettype none

package bsc_pkg;

    // Calibration register file layout.
    localparam int NumCoeff  = 6;
    localparam int AddrW     = $clog2(NumCoeff * 4);
    localparam int DataW     = 32;

    // Register indexes on the configuration port (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_SENS_BASE     = 3'd0,
        REG_OFFSET_BASE   = 3'd1,
        REG_SENS_TEMPCO   = 3'd2,
        REG_OFFSET_TEMPCO = 3'd3,
        REG_REF_TEMP      = 3'd4,
        REG_TEMP_SLOPE    = 3'd5
    } t_reg_idx;

    // Datapath pipeline depth, one valid bit per stage.
    localparam int NumStages = 9;

    // Temperature breakpoints in centidegrees.
    localparam int TempRef  = 2000;
    localparam int TempCold = -1500;

    // Shift amounts of the compensation polynomial.
    localparam int ShTemp = 23;
    localparam int ShT2   = 31;
    localparam int ShOff  = 7;
    localparam int ShSens = 8;
    localparam int ShProd = 21;
    localparam int ShPres = 15;

    // Calibration words plus the precomputed bad-calibration flag.
    typedef struct packed {
        logic [15:0] sens_base;
        logic [15:0] offset_base;
        logic [15:0] sens_tempco;
        logic [15:0] offset_tempco;
        logic [15:0] ref_temp;
        logic [15:0] temp_slope;
        logic        cal_bad;
    } t_coeffs;

    // Pipeline occupancy as seen from the top level.
    typedef struct packed {
        logic [NumStages-1:0] vld;
        logic                 full;
    } t_pipe_stat;

endpackage

`default_nettype wire

// ===== design/bsc_apb_regs.sv =====
// APB-style register file holding the six 16-bit calibration words.
// Depends on bsc_pkg for the register map and the coefficient struct.
`default_nettype none

module bsc_apb_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [bsc_pkg::AddrW-1:0] paddr,
    input  wire logic [bsc_pkg::DataW-1:0] pwdata,
    output logic      [bsc_pkg::DataW-1:0] prdata,
    output logic                           pready,
    output bsc_pkg::t_coeffs               o_coeffs
);
    import bsc_pkg::*;

    logic [15:0] r_coeff [NumCoeff];
    t_reg_idx    reg_idx;
    logic        wr_en;
    logic [15:0] any_bits;
    logic [15:0] all_bits;

    // Word index from the byte address; the low two bits are ignored.
    assign reg_idx = t_reg_idx'(paddr[AddrW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes; indexes past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumCoeff; k++) begin
                r_coeff[k] <= '0;
            end
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SENS_BASE:     r_coeff[REG_SENS_BASE]     <= pwdata[15:0];
                REG_OFFSET_BASE:   r_coeff[REG_OFFSET_BASE]   <= pwdata[15:0];
                REG_SENS_TEMPCO:   r_coeff[REG_SENS_TEMPCO]   <= pwdata[15:0];
                REG_OFFSET_TEMPCO: r_coeff[REG_OFFSET_TEMPCO] <= pwdata[15:0];
                REG_REF_TEMP:      r_coeff[REG_REF_TEMP]      <= pwdata[15:0];
                REG_TEMP_SLOPE:    r_coeff[REG_TEMP_SLOPE]    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux; unmapped addresses read as zero.
    always_comb begin
        unique case (reg_idx)
            REG_SENS_BASE:     prdata = DataW'(r_coeff[REG_SENS_BASE]);
            REG_OFFSET_BASE:   prdata = DataW'(r_coeff[REG_OFFSET_BASE]);
            REG_SENS_TEMPCO:   prdata = DataW'(r_coeff[REG_SENS_TEMPCO]);
            REG_OFFSET_TEMPCO: prdata = DataW'(r_coeff[REG_OFFSET_TEMPCO]);
            REG_REF_TEMP:      prdata = DataW'(r_coeff[REG_REF_TEMP]);
            REG_TEMP_SLOPE:    prdata = DataW'(r_coeff[REG_TEMP_SLOPE]);
            default:           prdata = '0;
        endcase
    end

    // Calibration is rejected when every word is zero or every word is all ones.
    always_comb begin
        any_bits = '0;
        all_bits = '1;
        for (int k = 0; k < NumCoeff; k++) begin
            any_bits = any_bits | r_coeff[k];
            all_bits = all_bits & r_coeff[k];
        end
    end

    assign o_coeffs.sens_base     = r_coeff[REG_SENS_BASE];
    assign o_coeffs.offset_base   = r_coeff[REG_OFFSET_BASE];
    assign o_coeffs.sens_tempco   = r_coeff[REG_SENS_TEMPCO];
    assign o_coeffs.offset_tempco = r_coeff[REG_OFFSET_TEMPCO];
    assign o_coeffs.ref_temp      = r_coeff[REG_REF_TEMP];
    assign o_coeffs.temp_slope    = r_coeff[REG_TEMP_SLOPE];
    assign o_coeffs.cal_bad       = (any_bits == '0) || (all_bits == '1);

endmodule

`default_nettype wire

// ===== design/bsc_pipe.sv =====
// Nine-stage compensation datapath with valid bits and per-stage stall enables.
// Depends on bsc_pkg for constants, the coefficient struct and the status struct.
`default_nettype none

module bsc_pipe (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [23:0]          i_raw_pressure,
    input  wire logic [23:0]          i_raw_temperature,
    input  wire bsc_pkg::t_coeffs     i_coeffs,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_valid_res,
    output logic signed [31:0]        o_temperature_centi_c,
    output logic [30:0]               o_pressure_pa,
    output bsc_pkg::t_pipe_stat       o_stat
);
    import bsc_pkg::*;

    localparam int Last = NumStages - 1;

    logic [NumStages-1:0] r_vld;
    logic [NumStages-1:0] en;

    // Stage 0: temperature difference.
    logic signed [24:0] n_dt;
    logic signed [24:0] r_s0_dt;
    logic [23:0]        r_s0_p;
    logic               r_s0_bad;
    // Stage 1: first-order products.
    logic signed [41:0] r_s1_m_temp;
    logic signed [41:0] r_s1_m_off;
    logic signed [41:0] r_s1_m_sens;
    logic signed [49:0] r_s1_m_sq;
    logic [23:0]        r_s1_p;
    logic               r_s1_bad;
    // Stage 2: first-order temperature, offset and sensitivity.
    logic signed [19:0] r_s2_temp;
    logic [18:0]        r_s2_t2;
    logic signed [35:0] r_s2_off;
    logic signed [35:0] r_s2_sens;
    logic [23:0]        r_s2_p;
    logic               r_s2_bad;
    // Stage 3: second-order squares.
    logic signed [19:0] n_d20;
    logic signed [19:0] n_d15;
    logic signed [39:0] r_s3_sq20;
    logic signed [39:0] r_s3_sq15;
    logic               r_s3_low;
    logic               r_s3_vlow;
    logic signed [20:0] r_s3_temp;
    logic signed [35:0] r_s3_off;
    logic signed [35:0] r_s3_sens;
    logic [23:0]        r_s3_p;
    logic               r_s3_bad;
    // Stage 4: second-order offset and sensitivity corrections.
    logic [42:0]        s20;
    logic [42:0]        s15;
    logic [42:0]        n_off2;
    logic [42:0]        n_sens2;
    logic [42:0]        r_s4_off2;
    logic [42:0]        r_s4_sens2;
    logic signed [20:0] r_s4_temp;
    logic signed [35:0] r_s4_off;
    logic signed [35:0] r_s4_sens;
    logic [23:0]        r_s4_p;
    logic               r_s4_bad;
    // Stage 5: corrected offset and sensitivity.
    logic signed [43:0] r_s5_off;
    logic signed [43:0] r_s5_sens;
    logic signed [20:0] r_s5_temp;
    logic [23:0]        r_s5_p;
    logic               r_s5_bad;
    // Stage 6: partial products of pressure count and sensitivity.
    logic [43:0]        r_s6_plo;
    logic signed [48:0] r_s6_phi;
    logic signed [43:0] r_s6_off;
    logic signed [20:0] r_s6_temp;
    logic               r_s6_bad;
    // Stage 7: full pressure product.
    logic signed [68:0] r_s7_prod;
    logic signed [43:0] r_s7_off;
    logic signed [20:0] r_s7_temp;
    logic               r_s7_bad;
    // Stage 8: output register.
    logic signed [48:0] n_x;
    logic signed [33:0] n_pres;
    logic [30:0]        n_pres_sat;
    logic               r_s8_valid_res;
    logic signed [31:0] r_s8_temp;
    logic [30:0]        r_s8_pres;

    // A stage may load when it is empty or when the stage after it moves.
    always_comb begin
        en[Last] = !r_vld[Last] || !i_stall;
        for (int k = Last - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    // Valid bits travel with their data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Raw temperature minus the reference count.
    assign n_dt = $signed({1'b0, i_raw_temperature})
                - $signed({1'b0, i_coeffs.ref_temp, 8'h00});

    // Square operands of the second-order correction.
    assign n_d20 = r_s2_temp - 20'(TempRef);
    assign n_d15 = r_s2_temp - 20'(TempCold);

    // Constant multiples by shift and add; the squares are never negative.
    always_comb begin
        s20     = 43'(unsigned'(r_s3_sq20));
        s15     = 43'(unsigned'(r_s3_sq15));
        n_off2  = ((s20 << 2) + s20) >> 1;
        n_sens2 = n_off2 >> 1;
        if (r_s3_vlow) begin
            n_off2  = n_off2 + ((s15 << 3) - s15);
            n_sens2 = n_sens2 + (((s15 << 3) + (s15 << 1) + s15) >> 1);
        end
        if (!r_s3_low) begin
            n_off2  = '0;
            n_sens2 = '0;
        end
    end

    // Final pressure, clamped at zero and at the largest 31-bit value.
    always_comb begin
        n_x    = 49'(r_s7_prod >>> ShProd) - 49'(r_s7_off);
        n_pres = 34'(n_x >>> ShPres);
        if (n_pres[33]) begin
            n_pres_sat = '0;
        end else if (n_pres[32:31] != 2'b00) begin
            n_pres_sat = '1;
        end else begin
            n_pres_sat = n_pres[30:0];
        end
    end

    // Datapath registers, each stage held while its enable is low.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_dt  <= n_dt;
            r_s0_p   <= i_raw_pressure;
            r_s0_bad <= (i_raw_pressure == '0) || (i_raw_temperature == '0)
                     || i_coeffs.cal_bad;
        end
        if (en[1]) begin
            r_s1_m_temp <= r_s0_dt * $signed({1'b0, i_coeffs.temp_slope});
            r_s1_m_off  <= r_s0_dt * $signed({1'b0, i_coeffs.offset_tempco});
            r_s1_m_sens <= r_s0_dt * $signed({1'b0, i_coeffs.sens_tempco});
            r_s1_m_sq   <= r_s0_dt * r_s0_dt;
            r_s1_p      <= r_s0_p;
            r_s1_bad    <= r_s0_bad;
        end
        if (en[2]) begin
            r_s2_temp <= 20'(TempRef) + 20'(r_s1_m_temp >>> ShTemp);
            r_s2_t2   <= 19'(r_s1_m_sq >>> ShT2);
            r_s2_off  <= $signed({4'b0, i_coeffs.offset_base, 16'h0000})
                       + 36'(r_s1_m_off >>> ShOff);
            r_s2_sens <= $signed({5'b0, i_coeffs.sens_base, 15'h0000})
                       + 36'(r_s1_m_sens >>> ShSens);
            r_s2_p    <= r_s1_p;
            r_s2_bad  <= r_s1_bad;
        end
        if (en[3]) begin
            r_s3_sq20 <= n_d20 * n_d20;
            r_s3_sq15 <= n_d15 * n_d15;
            r_s3_low  <= r_s2_temp < 20'(TempRef);
            r_s3_vlow <= r_s2_temp < 20'(TempCold);
            r_s3_temp <= (r_s2_temp < 20'(TempRef))
                       ? 21'(r_s2_temp) - $signed({2'b00, r_s2_t2}) : 21'(r_s2_temp);
            r_s3_off  <= r_s2_off;
            r_s3_sens <= r_s2_sens;
            r_s3_p    <= r_s2_p;
            r_s3_bad  <= r_s2_bad;
        end
        if (en[4]) begin
            r_s4_off2  <= n_off2;
            r_s4_sens2 <= n_sens2;
            r_s4_temp  <= r_s3_temp;
            r_s4_off   <= r_s3_off;
            r_s4_sens  <= r_s3_sens;
            r_s4_p     <= r_s3_p;
            r_s4_bad   <= r_s3_bad;
        end
        if (en[5]) begin
            r_s5_off  <= 44'(r_s4_off) - $signed({1'b0, r_s4_off2});
            r_s5_sens <= 44'(r_s4_sens) - $signed({1'b0, r_s4_sens2});
            r_s5_temp <= r_s4_temp;
            r_s5_p    <= r_s4_p;
            r_s5_bad  <= r_s4_bad;
        end
        if (en[6]) begin
            r_s6_plo  <= r_s5_p * r_s5_sens[19:0];
            r_s6_phi  <= $signed({1'b0, r_s5_p}) * $signed(r_s5_sens[43:20]);
            r_s6_off  <= r_s5_off;
            r_s6_temp <= r_s5_temp;
            r_s6_bad  <= r_s5_bad;
        end
        if (en[7]) begin
            r_s7_prod <= $signed({r_s6_phi, 20'h00000}) + $signed({25'b0, r_s6_plo});
            r_s7_off  <= r_s6_off;
            r_s7_temp <= r_s6_temp;
            r_s7_bad  <= r_s6_bad;
        end
        if (en[8]) begin
            r_s8_valid_res <= !r_s7_bad;
            r_s8_temp      <= r_s7_bad ? '0 : 32'(r_s7_temp);
            r_s8_pres      <= r_s7_bad ? '0 : n_pres_sat;
        end
    end

    assign o_valid               = r_vld[Last];
    assign o_valid_res           = r_s8_valid_res;
    assign o_temperature_centi_c = r_s8_temp;
    assign o_pressure_pa         = r_s8_pres;
    assign o_stat.vld            = r_vld;
    assign o_stat.full           = &r_vld;

endmodule

`default_nettype wire

// ===== design/baro_sensor_compensation.sv =====
// Barometric sensor compensation, top level: register file plus datapath pipeline.
// Depends on bsc_pkg, bsc_apb_regs and bsc_pipe.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one raw pressure count and one raw
//   temperature count per request. Output channel (o_valid / i_stall) returns
//   one result per request: a validity flag, temperature in centidegrees and
//   pressure in pascal. Six calibration words are written through the APB
//   port at byte addresses 0, 4, ..., 20; write them only while the block is
//   idle.
//   Depth: the datapath has nine register stages, set by the chain of
//   multiplications of the polynomial and its second-order term.
//   Throughput: one request per cycle while i_stall is low; every stage can
//   take a new request each cycle while it is empty or the stage after it moves.
//   Reset (i_rst_n low, synchronous): all calibration words clear to zero,
//   so results are flagged invalid until calibration is written, and the
//   pipeline empties.
//   Output stall: the last stage holds its result; upstream stages keep
//   filling empty slots, and o_stall rises only once every stage is full.
`default_nettype none

module baro_sensor_compensation (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [bsc_pkg::AddrW-1:0] paddr,
    input  wire logic [bsc_pkg::DataW-1:0] pwdata,
    output logic      [bsc_pkg::DataW-1:0] prdata,
    output logic                           pready,
    // Input channel
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [23:0]               i_raw_pressure,
    input  wire logic [23:0]               i_raw_temperature,
    // Output channel
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_valid_res,
    output logic signed [31:0]             o_temperature_centi_c,
    output logic [30:0]                    o_pressure_pa
);
    import bsc_pkg::*;

    t_coeffs    coeffs;
    t_pipe_stat pipe_stat;

    // Calibration registers.
    bsc_apb_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_coeffs (coeffs)
    );

    // Compensation pipeline.
    bsc_pipe u_pipe (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_raw_pressure        (i_raw_pressure),
        .i_raw_temperature     (i_raw_temperature),
        .i_coeffs              (coeffs),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_valid_res           (o_valid_res),
        .o_temperature_centi_c (o_temperature_centi_c),
        .o_pressure_pa         (o_pressure_pa),
        .o_stat                (pipe_stat)
    );

    // The input is held back only when every stage is occupied and the output stalls.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (pipe_stat.full && i_stall))
        else $error("input stalled while the pipeline has a free stage");

    // A rejected sample carries zero temperature and pressure.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |->
            (o_temperature_centi_c == 32'sd0 && o_pressure_pa == 31'd0))
        else $error("rejected result carries nonzero values");

    // Compensated temperature stays within the range of the 21-bit datapath.
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_centi_c < 32'sd1048576 &&
                     o_temperature_centi_c >= -32'sd1048576))
        else $error("temperature outside the datapath range");

    // An emptied pipeline shows no result on the following cycle.
    a_empty_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_stat.vld == '0) |=> (pipe_stat.vld[NumStages-1] == 1'b0))
        else $error("result appeared without passing through the pipeline");

endmodule

`default_nettype wire
